FILE: src/ipbl_pkg.sv
// shared types and constants for the ipv4 source address blocklist filter
package ipbl_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int ADDR_W            = 32;
  localparam int IN_TDATA_W        = 40;
  localparam int OUT_TDATA_W       = 8;

  typedef enum logic [1:0] {
    CMD_CHECK = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_DEL   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  // lookup token that walks the cell chain
  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] addr;
    logic              hit;
    logic              free;
  } scan_t;

  // table update broadcast to every cell
  typedef struct packed {
    logic              add;
    logic              del;
    logic [ADDR_W-1:0] addr;
  } commit_t;

endpackage

FILE: src/ipbl_cell.sv
// one table slot: valid bit, address, compare and hand-off of the lookup token
module ipbl_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  ipbl_pkg::scan_t   scan_in,
  output ipbl_pkg::scan_t   scan_out,
  input  ipbl_pkg::commit_t commit
);

  logic                        valid_r, valid_nxt;
  logic [ipbl_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic                        hit_mark_r, hit_mark_nxt;
  logic                        free_mark_r, free_mark_nxt;
  logic                        scan_vld_r;
  logic [ipbl_pkg::ADDR_W-1:0] scan_addr_r;
  logic                        scan_hit_r, scan_free_r;
  logic                        match;

  assign match = valid_r && (addr_r == scan_in.addr);

  always_comb begin
    valid_nxt     = valid_r;
    addr_nxt      = addr_r;
    hit_mark_nxt  = hit_mark_r;
    free_mark_nxt = free_mark_r;
    if (scan_in.vld) begin
      hit_mark_nxt  = match;
      free_mark_nxt = !valid_r && !scan_in.free;
    end
    if (commit.add && free_mark_r) begin
      valid_nxt = 1'b1;
      addr_nxt  = commit.addr;
    end
    if (commit.del && hit_mark_r) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      hit_mark_r  <= 1'b0;
      free_mark_r <= 1'b0;
      scan_vld_r  <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      hit_mark_r  <= hit_mark_nxt;
      free_mark_r <= free_mark_nxt;
      scan_vld_r  <= scan_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    addr_r      <= addr_nxt;
    scan_addr_r <= scan_in.addr;
    scan_hit_r  <= scan_in.hit || match;
    scan_free_r <= scan_in.free || !valid_r;
  end

  assign scan_out.vld  = scan_vld_r;
  assign scan_out.addr = scan_addr_r;
  assign scan_out.hit  = scan_hit_r;
  assign scan_out.free = scan_free_r;

endmodule

FILE: src/ipbl_ctrl.sv
// request sequencing, verdict and status decision, output register
module ipbl_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  ipbl_pkg::cmd_t              in_cmd,
  input  logic [ipbl_pkg::ADDR_W-1:0] in_addr,
  input  logic                        in_ipv4,
  output ipbl_pkg::scan_t             scan_in,
  input  ipbl_pkg::scan_t             scan_ret,
  output ipbl_pkg::commit_t           commit,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic                        out_drop,
  output ipbl_pkg::status_t           out_status
);

  ipbl_pkg::state_t            state_r, state_nxt;
  ipbl_pkg::cmd_t              cmd_r, cmd_nxt;
  logic [ipbl_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic                        ipv4_r, ipv4_nxt;
  logic                        hit_r, hit_nxt;
  logic                        free_r, free_nxt;
  logic                        out_vld_r, out_vld_nxt;
  logic                        drop_r, drop_nxt;
  ipbl_pkg::status_t           status_r, status_nxt;
  logic                        out_free;
  logic                        load;
  logic                        res_drop;
  ipbl_pkg::status_t           res_status;
  logic                        do_add, do_del;

  assign out_free = !out_vld_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ipbl_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = ipbl_pkg::S_SCAN;
      end
      ipbl_pkg::S_SCAN: begin
        if (scan_ret.vld) state_nxt = ipbl_pkg::S_FINISH;
      end
      ipbl_pkg::S_FINISH: begin
        if (out_free) state_nxt = ipbl_pkg::S_IDLE;
      end
      default: state_nxt = ipbl_pkg::S_IDLE;
    endcase
  end

  // result of the finished lookup
  always_comb begin
    res_drop   = 1'b0;
    res_status = ipbl_pkg::ST_OK;
    do_add     = 1'b0;
    do_del     = 1'b0;
    case (cmd_r)
      ipbl_pkg::CMD_CHECK: begin
        res_drop = ipv4_r && hit_r;
      end
      ipbl_pkg::CMD_ADD: begin
        if (hit_r) begin
          res_status = ipbl_pkg::ST_PRESENT;
        end else if (!free_r) begin
          res_status = ipbl_pkg::ST_FULL;
        end else begin
          do_add = 1'b1;
        end
      end
      ipbl_pkg::CMD_DEL: begin
        if (!hit_r) begin
          res_status = ipbl_pkg::ST_NOT_FOUND;
        end else begin
          do_del = 1'b1;
        end
      end
      default: begin
        res_drop = 1'b0;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_tready    = (state_r == ipbl_pkg::S_IDLE);
    scan_in.vld  = (state_r == ipbl_pkg::S_IDLE) && in_tvalid;
    scan_in.addr = in_addr;
    scan_in.hit  = 1'b0;
    scan_in.free = 1'b0;
    load         = (state_r == ipbl_pkg::S_FINISH) && out_free;
    commit.add   = load && do_add;
    commit.del   = load && do_del;
    commit.addr  = addr_r;
  end

  always_comb begin
    cmd_nxt     = cmd_r;
    addr_nxt    = addr_r;
    ipv4_nxt    = ipv4_r;
    hit_nxt     = hit_r;
    free_nxt    = free_r;
    drop_nxt    = drop_r;
    status_nxt  = status_r;
    out_vld_nxt = out_vld_r;
    if (scan_in.vld) begin
      cmd_nxt  = in_cmd;
      addr_nxt = in_addr;
      ipv4_nxt = in_ipv4;
    end
    if ((state_r == ipbl_pkg::S_SCAN) && scan_ret.vld) begin
      hit_nxt  = scan_ret.hit;
      free_nxt = scan_ret.free;
    end
    if (load) begin
      out_vld_nxt = 1'b1;
      drop_nxt    = res_drop;
      status_nxt  = res_status;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ipbl_pkg::S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    addr_r   <= addr_nxt;
    ipv4_r   <= ipv4_nxt;
    hit_r    <= hit_nxt;
    free_r   <= free_nxt;
    drop_r   <= drop_nxt;
    status_r <= status_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_drop   = drop_r;
  assign out_status = status_r;

  a_commit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(commit.add && commit.del))
    else $error("add and delete committed together");

  a_ret_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_ret.vld |-> (state_r == ipbl_pkg::S_SCAN))
    else $error("lookup token returned outside scan");

  a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_in.vld |=> (state_r == ipbl_pkg::S_SCAN))
    else $error("accepted request did not start a scan");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_vld_r)
    else $error("loaded result not presented");

endmodule

FILE: src/ip_blocklist_filter_top.sv
// ipv4 source address blocklist filter: chain of table cells and control
//
// in channel: one request per transfer; tdata carries the command (packet
// check, add address, delete address) and the address, tuser marks an ipv4
// packet. out channel: one response per request, in request order; tdata
// carries the drop verdict and the status code.
// the table is a row of TABLE_ENTRIES cells, each holding one address and its
// valid bit. a request sends a lookup token down the row, one cell per cycle;
// at the end of the row the control decides the verdict or status and, for a
// successful add or delete, updates the chosen cell by a broadcast to every cell.
// the next request is accepted only once the token has walked the whole cell
// row and the result is loaded; one request is in the table at a time.
// a finished response waits in the output register while the next request
// is accepted and scanned; if the receiver still stalls when that scan ends,
// the table update and the in channel wait until the register frees.
// reset: synchronous, active low; all valid bits clear, so the table is empty.
module ip_blocklist_filter_top #(
  parameter int TABLE_ENTRIES = ipbl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [1:0] cmd, [33:2] ip_addr, [39:34] zero
  input  logic [ipbl_pkg::IN_TDATA_W-1:0] in_tdata,
  // [0] is_ipv4
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] drop, [2:1] status, [7:3] zero
  output logic [ipbl_pkg::OUT_TDATA_W-1:0] out_tdata
);

  ipbl_pkg::scan_t   chain [TABLE_ENTRIES+1];
  ipbl_pkg::commit_t commit;
  logic              drop;
  ipbl_pkg::status_t status;

  ipbl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (ipbl_pkg::cmd_t'(in_tdata[1:0])),
    .in_addr    (in_tdata[ipbl_pkg::ADDR_W+1:2]),
    .in_ipv4    (in_tuser),
    .scan_in    (chain[0]),
    .scan_ret   (chain[TABLE_ENTRIES]),
    .commit     (commit),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_drop   (drop),
    .out_status (status)
  );

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ipbl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .scan_in  (chain[i]),
      .scan_out (chain[i+1]),
      .commit   (commit)
    );
  end

  assign out_tdata = {{(ipbl_pkg::OUT_TDATA_W-3){1'b0}}, status, drop};

endmodule
